### rtl/dbscc_pkg.sv
// Shared types and constants of the cluster-center block.
`default_nettype none
package dbscc_pkg;
    localparam int COORD_W = 16;
    localparam int LBL_W   = 7;
    localparam int EPS_W   = 33;
    localparam int MINN_W  = 7;

    localparam logic [LBL_W-1:0]  LBL_UNCL   = 7'd127;
    localparam logic [LBL_W-1:0]  LBL_NOISE  = 7'd126;
    localparam logic [EPS_W-1:0]  EPS_RESET  = 33'd25;
    localparam logic [MINN_W-1:0] MINN_RESET = 7'd4;

    // Register index, taken from address bit 3
    localparam logic REG_EPS  = 1'b0;
    localparam logic REG_MINN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRD,
        S_PCHK,
        S_CNT,
        S_FILL,
        S_QNEXT,
        S_QRD,
        S_QCHK,
        S_EXP,
        S_MEAN,
        S_DIV,
        S_FIN
    } t_state;
endpackage
`default_nettype wire

### rtl/dbscan_cluster_centers_core.sv
// Top level: point stores, label and seed-queue memories, clustering sequencer.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------------------
//  points    | start, busy                  | i_point_x, i_point_y, i_last_point
//  centers   | o_center_strobe (no stall)   | o_center_x, o_center_y, o_center_valid,
//            |                              | o_last_center
//  config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// Points load at one per cycle while busy is low. A point with last set starts
// clustering; every sweep over the stored points passes through memory read,
// squares and compare. Each seed or queued point costs one counting sweep plus
// one labeling sweep if it is core, and each cluster id one averaging sweep plus
// a divider run when non-empty.
// Synchronous reset clears control state only; the stores need no clearing pass.
`default_nettype none
module dbscan_cluster_centers_core #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dbscc_pkg::COORD_W-1:0] i_point_x,
    input  wire logic [dbscc_pkg::COORD_W-1:0] i_point_y,
    input  wire logic                          i_last_point,
    output logic                               o_center_strobe,
    output logic [dbscc_pkg::COORD_W-1:0]      o_center_x,
    output logic [dbscc_pkg::COORD_W-1:0]      o_center_y,
    output logic                               o_center_valid,
    output logic                               o_last_center
);
    import dbscc_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = AW + COORD_W;
    localparam int NW = SW + 1;
    localparam int DW = CW + 1;
    localparam int XY = 2 * COORD_W;

    t_state r_state;
    t_state n_state;

    // Configuration
    logic [EPS_W-1:0]  r_eps;
    logic [MINN_W-1:0] r_minn;
    logic              cfg_wr;

    // Memories
    logic [XY-1:0]    cmem [MAX_POINTS];
    logic [LBL_W-1:0] lmem [MAX_POINTS];
    logic [AW-1:0]    qmem [MAX_POINTS];
    logic [XY-1:0]    r_xy_q;
    logic [LBL_W-1:0] r_lbl_q;
    logic [AW-1:0]    r_q_q;
    logic [AW-1:0]    rd_addr;
    logic             cw_en;
    logic             lw_en;
    logic [AW-1:0]    lw_addr;
    logic [LBL_W-1:0] lw_data;
    logic             qw_en;

    // Sequencer registers
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_p, n_p;
    logic [AW-1:0]      r_c, n_c;
    logic [COORD_W-1:0] r_cx, n_cx;
    logic [COORD_W-1:0] r_cy, n_cy;
    logic               r_seed, n_seed;
    logic [CW-1:0]      r_ncl, n_ncl;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_tail, n_tail;
    logic               r_v1;
    logic [AW-1:0]      r_i1;
    logic [CW-1:0]      r_id, n_id;
    logic [SW-1:0]      r_sx, n_sx;
    logic [SW-1:0]      r_sy, n_sy;
    logic [CW-1:0]      r_mcnt, n_mcnt;
    logic               r_pend, n_pend;
    logic [COORD_W-1:0] r_pend_x, n_pend_x;
    logic [COORD_W-1:0] r_pend_y, n_pend_y;
    logic               r_stb, n_stb;
    logic [COORD_W-1:0] r_ox, n_ox;
    logic [COORD_W-1:0] r_oy, n_oy;
    logic               r_ovalid, n_ovalid;
    logic               r_olast, n_olast;

    // Status
    logic             accept;
    logic             scan_st;
    logic             iss;
    logic             scan_done;
    logic             p_last;
    logic             id_last;
    logic             q_empty;
    logic             core;
    logic             near_hit;
    logic             adv;
    logic             nid;
    logic [LBL_W-1:0] cur_id;

    // Distance pipeline and divider
    logic             d_valid;
    logic [AW-1:0]    d_idx;
    logic [LBL_W-1:0] d_label;
    logic             d_near;
    logic             div_go;
    logic             div_done;
    logic [NW-1:0]    div_qx;
    logic [NW-1:0]    div_qy;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == REG_MINN) ? {{(64-MINN_W){1'b0}}, r_minn}
                                           : {{(64-EPS_W){1'b0}}, r_eps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps  <= EPS_RESET;
            r_minn <= MINN_RESET;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_EPS) begin
                r_eps <= pwdata[EPS_W-1:0];
            end else begin
                r_minn <= pwdata[MINN_W-1:0];
            end
        end
    end

    // Shared decisions
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign scan_st   = (r_state inside {S_CNT, S_FILL, S_EXP, S_MEAN});
    assign iss       = scan_st && (r_idx != r_count);
    assign scan_done = scan_st && !iss && !r_v1 && !d_valid;
    assign p_last    = (CW'(r_p) + CW'(1)) == r_count;
    assign id_last   = (r_id + CW'(1)) == r_ncl;
    assign q_empty   = (r_head == r_tail);
    assign core      = 8'(r_n) >= 8'(r_minn);
    assign near_hit  = d_valid && d_near && (d_idx != r_c);
    assign cur_id    = LBL_W'(r_ncl);

    always_comb begin
        unique case (r_state)
            S_PRD:   rd_addr = r_p;
            S_QRD:   rd_addr = r_q_q;
            default: rd_addr = r_idx[AW-1:0];
        endcase
    end

    // Memories with registered reads
    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            cmem[r_count[AW-1:0]] <= {i_point_x, i_point_y};
        end
        r_xy_q <= cmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            lmem[lw_addr] <= lw_data;
        end
        r_lbl_q <= lmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (qw_en) begin
            qmem[r_tail[AW-1:0]] <= d_idx;
        end
        r_q_q <= qmem[r_head[AW-1:0]];
    end

    dbscc_dist #(
        .AW(AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_idx   (r_i1),
        .i_label (r_lbl_q),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_qx    (r_xy_q[XY-1:COORD_W]),
        .i_qy    (r_xy_q[COORD_W-1:0]),
        .i_eps   (r_eps),
        .o_valid (d_valid),
        .o_idx   (d_idx),
        .o_label (d_label),
        .o_near  (d_near)
    );

    dbscc_div #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num_x ({r_sx, 1'b0} + NW'(r_mcnt)),
        .i_num_y ({r_sy, 1'b0} + NW'(r_mcnt)),
        .i_den   ({r_mcnt, 1'b0}),
        .o_done  (div_done),
        .o_quo_x (div_qx),
        .o_quo_y (div_qy)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_last_point) n_state = S_PRD;
            end
            S_PRD: n_state = S_PCHK;
            S_PCHK: begin
                if (r_lbl_q == LBL_UNCL) n_state = S_CNT;
                else n_state = p_last ? S_MEAN : S_PRD;
            end
            S_CNT: begin
                if (scan_done) begin
                    if (core) n_state = r_seed ? S_FILL : S_EXP;
                    else if (r_seed) n_state = p_last ? S_MEAN : S_PRD;
                    else n_state = S_QNEXT;
                end
            end
            S_FILL: begin
                if (scan_done) n_state = S_QNEXT;
            end
            S_EXP: begin
                if (scan_done) n_state = S_QNEXT;
            end
            S_QNEXT: begin
                if (q_empty) n_state = p_last ? S_MEAN : S_PRD;
                else n_state = S_QRD;
            end
            S_QRD:  n_state = S_QCHK;
            S_QCHK: n_state = S_CNT;
            S_MEAN: begin
                if (scan_done) begin
                    if (r_mcnt != '0) n_state = S_DIV;
                    else if (id_last) n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (div_done) n_state = id_last ? S_FIN : S_MEAN;
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_count  = r_count;
        n_p      = r_p;
        n_c      = r_c;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_seed   = r_seed;
        n_ncl    = r_ncl;
        n_idx    = r_idx;
        n_n      = r_n;
        n_head   = r_head;
        n_tail   = r_tail;
        n_id     = r_id;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_mcnt   = r_mcnt;
        n_pend   = r_pend;
        n_pend_x = r_pend_x;
        n_pend_y = r_pend_y;
        n_stb    = 1'b0;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        cw_en    = 1'b0;
        lw_en    = 1'b0;
        lw_addr  = r_c;
        lw_data  = LBL_NOISE;
        qw_en    = 1'b0;
        div_go   = 1'b0;
        adv      = 1'b0;
        nid      = 1'b0;

        // Advance the sweep index
        if (iss) n_idx = r_idx + CW'(1);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count != CW'(MAX_POINTS)) begin
                        cw_en   = 1'b1;
                        lw_en   = 1'b1;
                        lw_addr = r_count[AW-1:0];
                        lw_data = LBL_UNCL;
                        n_count = r_count + CW'(1);
                    end
                    if (i_last_point) begin
                        n_p   = '0;
                        n_ncl = '0;
                    end
                end
            end
            S_PCHK: begin
                if (r_lbl_q == LBL_UNCL) begin
                    n_c    = r_p;
                    n_cx   = r_xy_q[XY-1:COORD_W];
                    n_cy   = r_xy_q[COORD_W-1:0];
                    n_seed = 1'b1;
                    n_idx  = '0;
                    n_n    = '0;
                end else begin
                    adv = 1'b1;
                end
            end
            S_CNT: begin
                if (near_hit) n_n = r_n + CW'(1);
                if (scan_done) begin
                    if (!core && r_seed) begin
                        lw_en = 1'b1;
                        n_ncl = r_ncl + CW'(1);
                        adv   = 1'b1;
                    end else if (core) begin
                        n_idx = '0;
                        if (r_seed) begin
                            lw_en   = 1'b1;
                            lw_data = cur_id;
                            n_head  = '0;
                            n_tail  = '0;
                        end
                    end
                end
            end
            S_FILL: begin
                // Label every neighbor of the seed and queue it
                if (near_hit) begin
                    lw_en   = 1'b1;
                    lw_addr = d_idx;
                    lw_data = cur_id;
                    if (r_tail != CW'(MAX_POINTS)) begin
                        qw_en  = 1'b1;
                        n_tail = r_tail + CW'(1);
                    end
                end
            end
            S_EXP: begin
                // Claim unclassified and noise neighbors; queue the unclassified
                if (near_hit && (d_label == LBL_UNCL || d_label == LBL_NOISE)) begin
                    lw_en   = 1'b1;
                    lw_addr = d_idx;
                    lw_data = cur_id;
                    if (d_label == LBL_UNCL && r_tail != CW'(MAX_POINTS)) begin
                        qw_en  = 1'b1;
                        n_tail = r_tail + CW'(1);
                    end
                end
            end
            S_QNEXT: begin
                if (q_empty) begin
                    n_ncl = r_ncl + CW'(1);
                    adv   = 1'b1;
                end else begin
                    n_head = r_head + CW'(1);
                end
            end
            S_QRD: begin
                n_c = r_q_q;
            end
            S_QCHK: begin
                n_cx   = r_xy_q[XY-1:COORD_W];
                n_cy   = r_xy_q[COORD_W-1:0];
                n_seed = 1'b0;
                n_idx  = '0;
                n_n    = '0;
            end
            S_MEAN: begin
                // Sum the members of the current id
                if (r_v1 && r_lbl_q == LBL_W'(r_id)) begin
                    n_sx   = r_sx + SW'(r_xy_q[XY-1:COORD_W]);
                    n_sy   = r_sy + SW'(r_xy_q[COORD_W-1:0]);
                    n_mcnt = r_mcnt + CW'(1);
                end
                if (scan_done) begin
                    if (r_mcnt != '0) div_go = 1'b1;
                    else nid = 1'b1;
                end
            end
            S_DIV: begin
                // Release the held center, hold the new one
                if (div_done) begin
                    if (r_pend) begin
                        n_stb    = 1'b1;
                        n_ox     = r_pend_x;
                        n_oy     = r_pend_y;
                        n_ovalid = 1'b1;
                        n_olast  = 1'b0;
                    end
                    n_pend   = 1'b1;
                    n_pend_x = div_qx[COORD_W-1:0];
                    n_pend_y = div_qy[COORD_W-1:0];
                    nid      = 1'b1;
                end
            end
            S_FIN: begin
                n_stb    = 1'b1;
                n_ox     = r_pend ? r_pend_x : '0;
                n_oy     = r_pend ? r_pend_y : '0;
                n_ovalid = r_pend;
                n_olast  = 1'b1;
                n_count  = '0;
            end
            default: begin
            end
        endcase

        // Move to the next point, or start averaging after the last one
        if (adv) begin
            if (p_last) begin
                n_id   = '0;
                n_idx  = '0;
                n_sx   = '0;
                n_sy   = '0;
                n_mcnt = '0;
                n_pend = 1'b0;
            end else begin
                n_p = r_p + AW'(1);
            end
        end

        // Move to the next cluster id
        if (nid && !id_last) begin
            n_id   = r_id + CW'(1);
            n_idx  = '0;
            n_sx   = '0;
            n_sy   = '0;
            n_mcnt = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_v1    <= 1'b0;
            r_stb   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_v1    <= iss;
            r_stb   <= n_stb;
            r_pend  <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_c      <= n_c;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_seed   <= n_seed;
        r_ncl    <= n_ncl;
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_i1     <= r_idx[AW-1:0];
        r_id     <= n_id;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_mcnt   <= n_mcnt;
        r_pend_x <= n_pend_x;
        r_pend_y <= n_pend_y;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_ovalid <= n_ovalid;
        r_olast  <= n_olast;
    end

    assign o_center_strobe = r_stb;
    assign o_center_x      = r_ox;
    assign o_center_y      = r_oy;
    assign o_center_valid  = r_ovalid;
    assign o_last_center   = r_olast;

`ifndef SYNTH
    a_busy_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_last_point))
        else $error("busy rose without a final point");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_center_strobe && o_last_center) |-> !busy)
        else $error("final center shown while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_center_strobe && !o_last_center) |-> busy)
        else $error("non-final center outside clustering");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_center_strobe && !o_center_valid) |->
            (o_last_center && o_center_x == '0 && o_center_y == '0))
        else $error("empty result malformed");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_head <= r_tail))
        else $error("seed queue head passed tail");
`endif
endmodule
`default_nettype wire

### rtl/dbscc_dist.sv
// Two-stage neighbor test: registered squares, then sum and radius compare.
`default_nettype none
module dbscc_dist #(
    parameter int AW = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [AW-1:0]                 i_idx,
    input  wire logic [dbscc_pkg::LBL_W-1:0]   i_label,
    input  wire logic [dbscc_pkg::COORD_W-1:0] i_cx,
    input  wire logic [dbscc_pkg::COORD_W-1:0] i_cy,
    input  wire logic [dbscc_pkg::COORD_W-1:0] i_qx,
    input  wire logic [dbscc_pkg::COORD_W-1:0] i_qy,
    input  wire logic [dbscc_pkg::EPS_W-1:0]   i_eps,
    output logic                               o_valid,
    output logic [AW-1:0]                      o_idx,
    output logic [dbscc_pkg::LBL_W-1:0]        o_label,
    output logic                               o_near
);
    import dbscc_pkg::*;

    logic signed [COORD_W:0]     dx;
    logic signed [COORD_W:0]     dy;
    logic signed [2*COORD_W+1:0] sqx;
    logic signed [2*COORD_W+1:0] sqy;
    logic [2*COORD_W-1:0]        r_sqx;
    logic [2*COORD_W-1:0]        r_sqy;
    logic                        r_valid;
    logic [AW-1:0]               r_idx;
    logic [LBL_W-1:0]            r_label;

    // Square the coordinate differences
    assign dx  = signed'({1'b0, i_qx}) - signed'({1'b0, i_cx});
    assign dy  = signed'({1'b0, i_qy}) - signed'({1'b0, i_cy});
    assign sqx = dx * dx;
    assign sqy = dy * dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqx   <= sqx[2*COORD_W-1:0];
        r_sqy   <= sqy[2*COORD_W-1:0];
        r_idx   <= i_idx;
        r_label <= i_label;
    end

    // Add the squares and compare with the radius
    assign o_near  = ({1'b0, r_sqx} + {1'b0, r_sqy}) <= i_eps;
    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_label = r_label;
endmodule
`default_nettype wire

### rtl/dbscc_div.sv
// Two-lane restoring divider with a shared divisor, one quotient bit per cycle.
`default_nettype none
module dbscc_div #(
    parameter int NW = 23,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num_x,
    input  wire logic [NW-1:0] i_num_y,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo_x,
    output logic [NW-1:0]      o_quo_y
);
    import dbscc_pkg::*;

    localparam int SCW = $clog2(NW + 1);

    logic           r_run;
    logic           r_done;
    logic [SCW-1:0] r_step;
    logic [DW-1:0]  r_den;
    logic [NW-1:0]  r_qx;
    logic [NW-1:0]  r_qy;
    logic [DW-1:0]  r_rx;
    logic [DW-1:0]  r_ry;
    logic [DW:0]    trial_x;
    logic [DW:0]    trial_y;
    logic           ge_x;
    logic           ge_y;

    // Shift in the next dividend bit and try the subtract
    assign trial_x = {r_rx, r_qx[NW-1]};
    assign trial_y = {r_ry, r_qy[NW-1]};
    assign ge_x    = trial_x >= {1'b0, r_den};
    assign ge_y    = trial_y >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_run && (r_step == SCW'(1));
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= SCW'(NW);
            end else if (r_run) begin
                r_step <= r_step - SCW'(1);
                if (r_step == SCW'(1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_qx  <= i_num_x;
            r_qy  <= i_num_y;
            r_rx  <= '0;
            r_ry  <= '0;
        end else if (r_run) begin
            r_rx <= ge_x ? DW'(trial_x - {1'b0, r_den}) : trial_x[DW-1:0];
            r_ry <= ge_y ? DW'(trial_y - {1'b0, r_den}) : trial_y[DW-1:0];
            r_qx <= {r_qx[NW-2:0], ge_x};
            r_qy <= {r_qy[NW-2:0], ge_y};
        end
    end

    assign o_done  = r_done;
    assign o_quo_x = r_qx;
    assign o_quo_y = r_qy;
endmodule
`default_nettype wire
